// ----- rtl/core/mpq_pkg.sv -----
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared constants and types for the max-priority ready queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

    // Default sizes, handed to the top-level parameters
    localparam int QUEUE_DEPTH_DEF   = 16;
    localparam int HANDLE_BITS_DEF   = 8;
    localparam int PRIORITY_BITS_DEF = 8;

    // Command field encoding on the input channel
    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

    // Classified operation passed from the front to the back
    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_op;

endpackage

// ----- rtl/core/mpq_if.sv -----
// ----------------------------------------------------------------------------
// mpq_if
// Valid/ready channels: command input and result output.
// ----------------------------------------------------------------------------
interface mpq_cmd_if #(
    parameter int HANDLE_BITS   = 8,
    parameter int PRIORITY_BITS = 8
);
    logic                     valid;
    logic                     ready;
    logic                     command;
    logic [HANDLE_BITS-1:0]   task_handle;
    logic [PRIORITY_BITS-1:0] task_priority;

    modport source (output valid, command, task_handle, task_priority, input ready);
    modport sink   (input valid, command, task_handle, task_priority, output ready);
endinterface

interface mpq_res_if #(
    parameter int HANDLE_BITS   = 8,
    parameter int PRIORITY_BITS = 8,
    parameter int OCC_BITS      = 5
);
    logic                     valid;
    logic                     ready;
    logic                     found;
    logic [HANDLE_BITS-1:0]   out_handle;
    logic [PRIORITY_BITS-1:0] out_priority;
    logic                     dropped;
    logic                     is_empty;
    logic [OCC_BITS-1:0]      occupancy;

    modport source (output valid, found, out_handle, out_priority, dropped, is_empty,
                    occupancy, input ready);
    modport sink   (input valid, found, out_handle, out_priority, dropped, is_empty,
                    occupancy, output ready);
endinterface

// ----- rtl/core/mpq_ram.sv -----
// ----------------------------------------------------------------------------
// mpq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mpq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/mpq_front.sv -----
// ----------------------------------------------------------------------------
// mpq_front
// Accepts commands, classifies them and buffers them in a two-entry queue.
// ----------------------------------------------------------------------------
module mpq_front
    import mpq_pkg::*;
#(
    parameter int HANDLE_BITS   = HANDLE_BITS_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    mpq_cmd_if.sink                  i_cmd,
    output logic                     o_op_valid,
    output t_op                      o_op,
    output logic [HANDLE_BITS-1:0]   o_handle,
    output logic [PRIORITY_BITS-1:0] o_priority,
    input  logic                     i_op_pop
);

    localparam int FifoDepth = 2;

    t_op                      r_op  [FifoDepth];
    logic [HANDLE_BITS-1:0]   r_hdl [FifoDepth];
    logic [PRIORITY_BITS-1:0] r_pri [FifoDepth];
    logic                     r_wp, r_rp;
    logic [1:0]               r_cnt;
    logic                     push, pop;
    t_op                      op_class;

    // Classify the incoming command
    assign op_class = (i_cmd.command == CMD_DEQUEUE) ? OP_DEQ : OP_ENQ;

    assign i_cmd.ready = (r_cnt != 2'(FifoDepth));
    assign push        = i_cmd.valid && i_cmd.ready;
    assign pop         = i_op_pop && (r_cnt != 2'd0);

    // Store a transfer at the write pointer
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_op[r_wp]  <= op_class;
            r_hdl[r_wp] <= i_cmd.task_handle;
            r_pri[r_wp] <= i_cmd.task_priority;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    assign o_op_valid = (r_cnt != 2'd0);
    assign o_op       = r_op[r_rp];
    assign o_handle   = r_hdl[r_rp];
    assign o_priority = r_pri[r_rp];

endmodule

// ----- rtl/core/mpq_back.sv -----
// ----------------------------------------------------------------------------
// mpq_back
// Executes queue operations: tail append, linear max scan, shift-down
// compaction, and holds the result in an output register.
// ----------------------------------------------------------------------------
module mpq_back
    import mpq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
    parameter int HANDLE_BITS   = HANDLE_BITS_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_op_valid,
    input  t_op                      i_op,
    input  logic [HANDLE_BITS-1:0]   i_handle,
    input  logic [PRIORITY_BITS-1:0] i_priority,
    output logic                     o_op_pop,
    mpq_res_if.source                o_res
);

    localparam int IdxW  = $clog2(QUEUE_DEPTH);
    localparam int CntW  = $clog2(QUEUE_DEPTH + 1);
    localparam int WordW = HANDLE_BITS + PRIORITY_BITS;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]               r_state, n_state;
    logic [CntW-1:0]          r_count, n_count;
    logic [CntW-1:0]          r_rd_addr, n_rd_addr;
    logic                     r_pend, n_pend;
    logic [IdxW-1:0]          r_pend_addr, n_pend_addr;
    logic [IdxW-1:0]          r_best_idx, n_best_idx;
    logic [HANDLE_BITS-1:0]   r_best_hdl, n_best_hdl;
    logic [PRIORITY_BITS-1:0] r_best_pri, n_best_pri;

    logic                     r_out_valid, n_out_valid;
    logic                     r_found;
    logic [HANDLE_BITS-1:0]   r_out_hdl;
    logic [PRIORITY_BITS-1:0] r_out_pri;
    logic                     r_dropped;
    logic [CntW-1:0]          r_occ;

    logic                     ld;
    logic                     ld_found, ld_dropped;
    logic [HANDLE_BITS-1:0]   ld_hdl;
    logic [PRIORITY_BITS-1:0] ld_pri;
    logic [CntW-1:0]          ld_occ;

    logic                     ram_we, ram_re;
    logic [IdxW-1:0]          ram_waddr, ram_raddr;
    logic [WordW-1:0]         ram_wdata, ram_rdata;
    logic [HANDLE_BITS-1:0]   rd_hdl;
    logic [PRIORITY_BITS-1:0] rd_pri;
    logic                     out_free, full, rd_more;

    mpq_ram #(
        .WIDTH (WordW),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_hdl   = ram_rdata[WordW-1:PRIORITY_BITS];
    assign rd_pri   = ram_rdata[PRIORITY_BITS-1:0];
    assign out_free = !r_out_valid || o_res.ready;
    assign full     = (r_count == CntW'(QUEUE_DEPTH));
    assign rd_more  = (r_rd_addr < r_count);

    // Sequencer: append, scan, compact, report
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rd_addr   = r_rd_addr;
        n_pend      = 1'b0;
        n_pend_addr = r_pend_addr;
        n_best_idx  = r_best_idx;
        n_best_hdl  = r_best_hdl;
        n_best_pri  = r_best_pri;
        n_out_valid = r_out_valid && !o_res.ready;
        ld          = 1'b0;
        ld_found    = 1'b0;
        ld_dropped  = 1'b0;
        ld_hdl      = '0;
        ld_pri      = '0;
        ld_occ      = r_count;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = '0;
        o_op_pop    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_op_valid) begin
                    unique case (i_op)
                        OP_ENQ: begin
                            if (out_free) begin
                                o_op_pop = 1'b1;
                                ld       = 1'b1;
                                if (!full) begin
                                    ram_we    = 1'b1;
                                    ram_waddr = r_count[IdxW-1:0];
                                    ram_wdata = {i_handle, i_priority};
                                    n_count   = r_count + CntW'(1);
                                    ld_occ    = r_count + CntW'(1);
                                end else begin
                                    ld_dropped = 1'b1;
                                end
                            end
                        end
                        OP_DEQ: begin
                            if (r_count == '0) begin
                                if (out_free) begin
                                    o_op_pop = 1'b1;
                                    ld       = 1'b1;
                                end
                            end else begin
                                o_op_pop  = 1'b1;
                                n_rd_addr = '0;
                                n_state   = S_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_SCAN: begin
                // Keep the first strictly larger priority, so ties stay with the oldest
                if (r_pend && ((r_pend_addr == '0) || (rd_pri > r_best_pri))) begin
                    n_best_idx = r_pend_addr;
                    n_best_hdl = rd_hdl;
                    n_best_pri = rd_pri;
                end
                if (rd_more) begin
                    ram_re      = 1'b1;
                    ram_raddr   = r_rd_addr[IdxW-1:0];
                    n_rd_addr   = r_rd_addr + CntW'(1);
                    n_pend      = 1'b1;
                    n_pend_addr = r_rd_addr[IdxW-1:0];
                end else if (r_pend) begin
                    n_rd_addr = CntW'(n_best_idx) + CntW'(1);
                    n_state   = S_SHIFT;
                end
            end

            S_SHIFT: begin
                // Move each later entry down by one place
                if (r_pend) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pend_addr - IdxW'(1);
                    ram_wdata = ram_rdata;
                end
                if (rd_more) begin
                    ram_re      = 1'b1;
                    ram_raddr   = r_rd_addr[IdxW-1:0];
                    n_rd_addr   = r_rd_addr + CntW'(1);
                    n_pend      = 1'b1;
                    n_pend_addr = r_rd_addr[IdxW-1:0];
                end else if (!r_pend) begin
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (out_free) begin
                    ld       = 1'b1;
                    ld_found = 1'b1;
                    ld_hdl   = r_best_hdl;
                    ld_pri   = r_best_pri;
                    ld_occ   = r_count - CntW'(1);
                    n_count  = r_count - CntW'(1);
                    n_state  = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase

        if (ld) begin
            n_out_valid = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Scan bookkeeping and result payload
    always_ff @(posedge i_clk) begin
        r_rd_addr   <= n_rd_addr;
        r_pend_addr <= n_pend_addr;
        r_best_idx  <= n_best_idx;
        r_best_hdl  <= n_best_hdl;
        r_best_pri  <= n_best_pri;
        if (ld) begin
            r_found   <= ld_found;
            r_out_hdl <= ld_hdl;
            r_out_pri <= ld_pri;
            r_dropped <= ld_dropped;
            r_occ     <= ld_occ;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.found        = r_found;
    assign o_res.out_handle   = r_out_hdl;
    assign o_res.out_priority = r_out_pri;
    assign o_res.dropped      = r_dropped;
    assign o_res.is_empty     = (r_occ == '0);
    assign o_res.occupancy    = r_occ;

endmodule

// ----- rtl/core/max_priority_ready_queue.sv -----
// ----------------------------------------------------------------------------
// max_priority_ready_queue
// Bounded ready queue of task handles served by largest priority, oldest
// first on ties.
//
//   Channel  Dir  Payload                                          Transfer
//   i_cmd    in   command, task_handle, task_priority              valid & ready
//   o_res    out  found, out_handle, out_priority, dropped,        valid & ready
//                 is_empty, occupancy
//
// A dequeue makes one RAM read per entry for the max scan and one read/write
// pair per later entry for compaction.
// Reset clears the count, the command buffer and the result register; entry
// storage is not cleared. Two commands buffer ahead of the execution unit;
// a held result stalls the unit, and command intake only once that buffer
// is full.
// ----------------------------------------------------------------------------
module max_priority_ready_queue
    import mpq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
    parameter int HANDLE_BITS   = HANDLE_BITS_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mpq_cmd_if.sink   i_cmd,
    mpq_res_if.source o_res
);

    logic                     op_valid;
    t_op                      op;
    logic [HANDLE_BITS-1:0]   op_hdl;
    logic [PRIORITY_BITS-1:0] op_pri;
    logic                     op_pop;

    // Command intake and classification
    mpq_front #(
        .HANDLE_BITS   (HANDLE_BITS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (i_cmd),
        .o_op_valid (op_valid),
        .o_op       (op),
        .o_handle   (op_hdl),
        .o_priority (op_pri),
        .i_op_pop   (op_pop)
    );

    // Queue storage and execution
    mpq_back #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .HANDLE_BITS   (HANDLE_BITS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (op_valid),
        .i_op       (op),
        .i_handle   (op_hdl),
        .i_priority (op_pri),
        .o_op_pop   (op_pop),
        .o_res      (o_res)
    );

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Checks the max-priority ready queue against a queue model kept in the
// bench. Each command transfer is scored at once, and the expected result
// is matched in order against every result transfer. Directed tests cover
// dequeue when empty, oldest-first ties, field extremes and overflow. A
// random mix then sweeps occupancy between empty and full, with bursty
// command traffic and a result stall pattern.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mpq_pkg::*;

    localparam int DEPTH       = QUEUE_DEPTH_DEF;
    localparam int HB          = HANDLE_BITS_DEF;
    localparam int PB          = PRIORITY_BITS_DEF;
    localparam int OCC_BITS    = $clog2(DEPTH + 1);
    localparam int IDLE_LIMIT  = 5000;
    localparam int TAIL_CYCLES = 2 * DEPTH + 16;
    localparam int SHOWN_MAX   = 10;

    typedef struct packed {
        logic                found;
        logic [HB-1:0]       handle;
        logic [PB-1:0]       prio;
        logic                dropped;
        logic                is_empty;
        logic [OCC_BITS-1:0] occupancy;
    } t_sched_result;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_CADENCE
    } t_rx_mode;

    logic i_clk;
    logic i_rst_n;

    mpq_cmd_if #(.HANDLE_BITS(HB), .PRIORITY_BITS(PB)) cmd_ch ();
    mpq_res_if #(.HANDLE_BITS(HB), .PRIORITY_BITS(PB), .OCC_BITS(OCC_BITS)) res_ch ();

    max_priority_ready_queue #(
        .QUEUE_DEPTH  (DEPTH),
        .HANDLE_BITS  (HB),
        .PRIORITY_BITS(PB)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_ch),
        .o_res  (res_ch)
    );

    // Queue contents as the bench sees them, oldest first
    logic [HB-1:0] held_handles[$];
    logic [PB-1:0] held_prios[$];

    t_sched_result pending_results[$];

    int mismatch_count = 0;
    int idle_cycles    = 0;
    int burst_left     = 0;
    bit gaps_enabled   = 1'b1;

    // Clock: 10 ns period
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Apply one command to the held queue and return the result it yields
    function automatic t_sched_result serve_command(logic command, logic [HB-1:0] handle,
                                                    logic [PB-1:0] prio);
        t_sched_result res;
        int            best;
        res = '0;
        if (command == CMD_ENQUEUE) begin
            if (held_handles.size() < DEPTH) begin
                held_handles.push_back(handle);
                held_prios.push_back(prio);
            end else begin
                res.dropped = 1'b1;
            end
        end else if (held_handles.size() > 0) begin
            // first strictly larger wins, so ties stay with the oldest
            best = 0;
            for (int i = 1; i < held_prios.size(); i++) begin
                if (held_prios[i] > held_prios[best]) begin
                    best = i;
                end
            end
            res.found  = 1'b1;
            res.handle = held_handles[best];
            res.prio   = held_prios[best];
            held_handles.delete(best);
            held_prios.delete(best);
        end
        res.is_empty  = (held_handles.size() == 0);
        res.occupancy = OCC_BITS'(held_handles.size());
        return res;
    endfunction

    function automatic string describe(t_sched_result res);
        return $sformatf("found=%0d handle=%02h prio=%02h dropped=%0d empty=%0d occ=%0d",
                         res.found, res.handle, res.prio, res.dropped, res.is_empty,
                         res.occupancy);
    endfunction

    task automatic note_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= SHOWN_MAX) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    // Send one command, with an occasional gap between bursts
    task automatic send_command(logic command, logic [HB-1:0] handle, logic [PB-1:0] prio);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (gaps_enabled) begin
                gap = $urandom_range(1, 8);
            end
        end
        // idle with junk on the payload
        repeat (gap) begin
            @(negedge i_clk);
            cmd_ch.valid         = 1'b0;
            cmd_ch.command       = 1'($urandom_range(0, 1));
            cmd_ch.task_handle   = HB'($urandom_range(0, 255));
            cmd_ch.task_priority = PB'($urandom_range(0, 255));
        end
        @(negedge i_clk);
        cmd_ch.valid         = 1'b1;
        cmd_ch.command       = command;
        cmd_ch.task_handle   = handle;
        cmd_ch.task_priority = prio;
        do @(posedge i_clk); while (!cmd_ch.ready);
        pending_results.push_back(serve_command(command, handle, prio));
        burst_left--;
    endtask

    // Stop sending and hold until every expected result has come back
    task automatic wait_results_drained();
        @(negedge i_clk);
        cmd_ch.valid = 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic test_dequeue_empty();
        send_command(CMD_DEQUEUE, 8'hFF, 8'hFF);
        wait_results_drained();
    endtask

    task automatic test_tie_order();
        send_command(CMD_ENQUEUE, 8'h11, 8'h07);
        send_command(CMD_ENQUEUE, 8'h22, 8'h07);
        send_command(CMD_ENQUEUE, 8'h33, 8'h03);
        repeat (3) send_command(CMD_DEQUEUE, 8'h00, 8'h00);
        wait_results_drained();
    endtask

    // Fill to the brim with extreme fields, overflow once, take the top entry
    task automatic test_fill_overflow();
        logic [PB-1:0] fill_prios [DEPTH] = '{8'h40, 8'h00, 8'h7F, 8'hFF, 8'h80, 8'h01,
                                             8'hFE, 8'h10, 8'h55, 8'hAA, 8'h20, 8'h00,
                                             8'hFF, 8'h33, 8'h08, 8'hC0};
        for (int i = 0; i < DEPTH; i++) begin
            send_command(CMD_ENQUEUE, HB'(i * 17), fill_prios[i]);
        end
        send_command(CMD_ENQUEUE, 8'hEE, 8'hFF);
        send_command(CMD_DEQUEUE, 8'h5A, 8'hA5);
        wait_results_drained();
    endtask

    task automatic test_back_to_back();
        gaps_enabled = 1'b0;
        repeat (60) begin
            send_command(($urandom_range(0, 99) < 60) ? CMD_ENQUEUE : CMD_DEQUEUE,
                         HB'($urandom_range(0, 255)), PB'($urandom_range(0, 255)));
        end
        wait_results_drained();
        gaps_enabled = 1'b1;
    endtask

    // Phases with different enqueue bias sweep the occupancy up and down
    task automatic test_random_mix();
        int            enq_pct;
        int            prio_top;
        logic          command;
        logic [PB-1:0] prio;
        for (int phase = 0; phase < 12; phase++) begin
            case ($urandom_range(0, 2))
                0:       enq_pct = 20;
                1:       enq_pct = 50;
                default: enq_pct = 80;
            endcase
            // narrow priority range forces many ties
            prio_top     = $urandom_range(0, 1) ? 255 : 3;
            gaps_enabled = ($urandom_range(0, 3) != 0);
            repeat (60) begin
                command = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQUEUE : CMD_DEQUEUE;
                prio    = PB'($urandom_range(0, prio_top));
                if (prio_top != 255 && $urandom_range(0, 1)) begin
                    prio = ~prio;
                end
                send_command(command, HB'($urandom_range(0, 255)), prio);
            end
        end
        gaps_enabled = 1'b1;
        wait_results_drained();
    endtask

    // Result side: stall on a pattern that changes every so often
    initial begin : result_stall
        t_rx_mode rx_mode;
        int       rx_left;
        int       rx_tick;
        res_ch.ready = 1'b0;
        rx_mode      = RX_OPEN;
        rx_left      = 0;
        rx_tick      = 0;
        forever begin
            @(negedge i_clk);
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_left = $urandom_range(20, 200);
            end
            rx_left--;
            rx_tick++;
            case (rx_mode)
                RX_OPEN:   res_ch.ready = 1'b1;
                RX_COIN:   res_ch.ready = 1'($urandom_range(0, 1));
                RX_SPARSE: res_ch.ready = ($urandom_range(0, 4) == 0);
                default:   res_ch.ready = ((rx_tick % 8) < 5);
            endcase
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_sched_result got;
        t_sched_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.found     = res_ch.found;
            got.handle    = res_ch.out_handle;
            got.prio      = res_ch.out_priority;
            got.dropped   = res_ch.dropped;
            got.is_empty  = res_ch.is_empty;
            got.occupancy = res_ch.occupancy;
            if (pending_results.size() == 0) begin
                note_mismatch({"unexpected result ", describe(got)});
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    note_mismatch({"expected ", describe(want), " got ", describe(got)});
                end
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin : main_sequence
        i_rst_n              = 1'b0;
        cmd_ch.valid         = 1'b0;
        cmd_ch.command       = CMD_ENQUEUE;
        cmd_ch.task_handle   = '0;
        cmd_ch.task_priority = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_dequeue_empty();
        test_tie_order();
        test_fill_overflow();
        test_back_to_back();
        test_random_mix();

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
